>>> design/sbrb_pkg.sv
// Shared constants and types for the scrollback ring buffer.
// No dependencies; imported by design/scrollback_ring_buffer.sv.
`default_nettype none

package sbrb_pkg;

	// Ring size; pointers wrap naturally, so this must stay a power of two.
	localparam int BUF_SIZE = 4096;
	localparam int PTR_W    = $clog2(BUF_SIZE);
	localparam int CNT_W    = 12;  // width of column, used and offset fields
	localparam int BYTE_W   = 8;
	localparam int LEN_W    = 16;
	localparam int LINE_W   = 16;

	localparam logic [BYTE_W-1:0] NEWLINE = 8'h0A;

	localparam logic OP_APPEND = 1'b0;
	localparam logic OP_READ   = 1'b1;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_TOO_LONG = 2'd1,
		STAT_RANGE    = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WRITE,
		ST_READ
	} state_t;

endpackage

`default_nettype wire

>>> design/sbrb_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module sbrb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

>>> design/scrollback_ring_buffer.sv
// Scrollback ring buffer top level: byte ring, eviction scanner, result register.
// Depends on sbrb_pkg and sbrb_ram.
`default_nettype none

// Channel   | Handshake              | Payload
// ----------+------------------------+----------------------------------------------
// item in   | start & !busy          | operation, char_byte, chunk_first,
//           |                        | chunk_length, chunk_last, read_offset
// result    | done (1-cycle strobe)  | read_byte, line_count, cursor_column,
//           |                        | used_length, status
//
// Appends that fit are stored in the accept cycle, one item per clock, busy stays low.
// An append that needs room scans oldest bytes out of the ring RAM at one byte per
// clock (the RAM read port sets that pace), then stores the held byte in ST_WRITE.
// Reads hold busy while in ST_READ: the accept clock addresses the RAM, and ST_READ
// takes the registered data. A result strobes in the cycle after its item finishes.
// Reset needs no clearing pass: ring RAM data is only used inside the written region.
// The receiver cannot stall: a result is shown for its single cycle regardless.

module scrollback_ring_buffer
	import sbrb_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic              operation,
	input  wire logic [BYTE_W-1:0] char_byte,
	input  wire logic              chunk_first,
	input  wire logic [LEN_W-1:0]  chunk_length,
	input  wire logic              chunk_last,
	input  wire logic [CNT_W-1:0]  read_offset,
	output logic                   done,
	output logic      [BYTE_W-1:0] read_byte,
	output logic      [LINE_W-1:0] line_count,
	output logic      [CNT_W-1:0]  cursor_column,
	output logic      [CNT_W-1:0]  used_length,
	output logic      [1:0]        status
);

	// control state
	state_t            state_q, state_d;
	logic [PTR_W-1:0]  wp_q, wp_d;       // write point
	logic [PTR_W-1:0]  old_q, old_d;     // oldest stored byte
	logic [PTR_W-1:0]  nlp_q, nlp_d;     // position just after the newest stored newline
	logic              nlv_q, nlv_d;     // that newline is still in the ring
	logic [LINE_W-1:0] lines_q, lines_d;
	logic              drop_q, drop_d;   // rest of an oversize chunk is being discarded

	// item held across an eviction scan
	logic [PTR_W-1:0]  need_q, need_d;
	logic [BYTE_W-1:0] hold_byte_q, hold_byte_d;
	logic              hold_last_q, hold_last_d;
	logic              rd_err_q, rd_err_d;

	// result register
	logic              done_q;
	logic [BYTE_W-1:0] rbyte_q;
	logic [LINE_W-1:0] lines_out_q;
	logic [CNT_W-1:0]  col_q;
	logic [CNT_W-1:0]  used_out_q;
	status_t           status_q;

	logic              emit;
	logic [BYTE_W-1:0] emit_byte;
	status_t           emit_status;
	logic [PTR_W-1:0]  emit_col;
	logic [PTR_W-1:0]  emit_used;

	// RAM port
	logic              ram_we;
	logic [BYTE_W-1:0] ram_wdata;
	logic [PTR_W-1:0]  ram_raddr;
	logic [BYTE_W-1:0] ram_rdata;
	logic              wr_last;

	// decode of an incoming item
	logic              accept;
	logic [PTR_W-1:0]  used_cur;
	logic              len_bad;
	logic [PTR_W-1:0]  need_in;
	logic              is_read, app_reject, app_skip, app_store, app_fits;

	// scan step
	logic [PTR_W-1:0]  old_inc;
	logic [PTR_W-1:0]  used_after;
	logic              scan_nl, line_done, scan_fits;

	// free space strictly exceeds need, i.e. used + need < BUF_SIZE
	function automatic logic fits(input logic [PTR_W-1:0] used, input logic [PTR_W-1:0] need);
		logic [PTR_W:0] sum;
		sum = {1'b0, used} + {1'b0, need};
		return sum < (PTR_W+1)'(BUF_SIZE);
	endfunction

	assign accept     = start && (state_q == ST_IDLE);
	assign used_cur   = wp_q - old_q;
	assign len_bad    = {16'd0, chunk_length} >= 32'(BUF_SIZE);
	// a zero length behaves as one: the byte itself still has to fit
	assign need_in    = (chunk_first && (chunk_length != '0)) ? PTR_W'(chunk_length)
	                                                           : PTR_W'(1);
	assign is_read    = (operation == OP_READ);
	assign app_reject = !is_read && chunk_first && len_bad;
	assign app_skip   = !is_read && !chunk_first && drop_q;
	assign app_store  = !is_read && !app_reject && !app_skip;
	assign app_fits   = fits(used_cur, need_in);

	// RAM data during a scan belongs to old_q; a line ends on a newline or at the write point
	assign old_inc    = old_q + PTR_W'(1);
	assign used_after = wp_q - old_inc;
	assign scan_nl    = (ram_rdata == NEWLINE);
	assign line_done  = scan_nl || (old_inc == wp_q);
	assign scan_fits  = fits(used_after, need_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (is_read) begin
						state_d = ST_READ;
					end else if (app_store && !app_fits) begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (line_done && scan_fits) begin
					state_d = ST_WRITE;
				end
			end
			ST_WRITE: state_d = ST_IDLE;
			ST_READ:  state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// datapath and outputs of the sequencer
	always_comb begin
		wp_d        = wp_q;
		old_d       = old_q;
		nlp_d       = nlp_q;
		nlv_d       = nlv_q;
		lines_d     = lines_q;
		drop_d      = drop_q;
		need_d      = need_q;
		hold_byte_d = hold_byte_q;
		hold_last_d = hold_last_q;
		rd_err_d    = rd_err_q;
		ram_we      = 1'b0;
		ram_wdata   = char_byte;
		wr_last     = chunk_last;
		ram_raddr   = old_q;
		emit        = 1'b0;
		emit_byte   = '0;
		emit_status = STAT_OK;

		case (state_q)
			ST_IDLE: begin
				if (is_read) begin
					ram_raddr = old_q + PTR_W'(read_offset);
				end
				if (accept) begin
					if (is_read) begin
						rd_err_d = PTR_W'(read_offset) >= used_cur;
					end else if (app_reject) begin
						drop_d      = !chunk_last;
						emit        = 1'b1;
						emit_status = STAT_TOO_LONG;
					end else if (app_skip) begin
						if (chunk_last) begin
							drop_d = 1'b0;
						end
					end else begin
						if (chunk_first) begin
							drop_d = 1'b0;
						end
						need_d      = need_in;
						hold_byte_d = char_byte;
						hold_last_d = chunk_last;
						ram_we      = app_fits;
					end
				end
			end
			ST_SCAN: begin
				// read ahead of the byte just consumed, so the scan runs a byte a clock
				ram_raddr = old_inc;
				old_d     = old_inc;
				if (line_done) begin
					if (lines_q != '0) begin
						lines_d = lines_q - LINE_W'(1);
					end
					// the newest newline just left the ring
					if (nlv_q && (old_inc == nlp_q)) begin
						nlv_d = 1'b0;
					end
				end
			end
			ST_WRITE: begin
				ram_we    = 1'b1;
				ram_wdata = hold_byte_q;
				wr_last   = hold_last_q;
			end
			ST_READ: begin
				emit        = 1'b1;
				emit_byte   = rd_err_q ? '0 : ram_rdata;
				emit_status = rd_err_q ? STAT_RANGE : STAT_OK;
			end
			default: begin
			end
		endcase

		// append one byte at the write point
		if (ram_we) begin
			wp_d = wp_q + PTR_W'(1);
			if (ram_wdata == NEWLINE) begin
				nlp_d = wp_q + PTR_W'(1);
				nlv_d = 1'b1;
				if (lines_q != '1) begin
					lines_d = lines_q + LINE_W'(1);
				end
			end
			if (wr_last) begin
				emit = 1'b1;
			end
		end

		// results report the state as it stands after this item
		emit_used = wp_d - old_d;
		emit_col  = nlv_d ? (wp_d - nlp_d) : emit_used;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			wp_q    <= '0;
			old_q   <= '0;
			nlv_q   <= 1'b0;
			lines_q <= LINE_W'(1);
			drop_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			wp_q    <= wp_d;
			old_q   <= old_d;
			nlv_q   <= nlv_d;
			lines_q <= lines_d;
			drop_q  <= drop_d;
			done_q  <= emit;
		end
	end

	always_ff @(posedge clk) begin
		nlp_q       <= nlp_d;
		need_q      <= need_d;
		hold_byte_q <= hold_byte_d;
		hold_last_q <= hold_last_d;
		rd_err_q    <= rd_err_d;
		if (emit) begin
			rbyte_q     <= emit_byte;
			lines_out_q <= lines_d;
			col_q       <= CNT_W'(emit_col);
			used_out_q  <= CNT_W'(emit_used);
			status_q    <= emit_status;
		end
	end

	sbrb_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (BUF_SIZE)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wp_q),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign busy          = (state_q != ST_IDLE);
	assign done          = done_q;
	assign read_byte     = rbyte_q;
	assign line_count    = lines_out_q;
	assign cursor_column = col_q;
	assign used_length   = used_out_q;
	assign status        = status_q;

`ifndef SYNTHESIS
	// a byte is never stored into a full ring
	assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (used_cur != '1))
		else $error("store into full ring");

	// the scan only runs while there is something left to drop
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (old_q != wp_q))
		else $error("scan on empty ring");

	// once the scan hands over, the held byte and chunk fit
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WRITE) |-> fits(used_cur, need_q))
		else $error("eviction stopped early");

	// a read in ST_READ always answers in the following cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |=> done)
		else $error("read result missing");

	// line count saturates instead of wrapping
	assert property (@(posedge clk) disable iff (!arst_n)
		(lines_q == '0) |=> (lines_q != '1))
		else $error("line count wrapped");
`endif

endmodule

`default_nettype wire
